>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the cache tag store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TPLRU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define TPLRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tplru_pkg.sv
// ----------------------------------------------------------------------------
// tplru_pkg
// Sizes, beat types and tree pseudo-LRU helpers for the cache tag store.
// ----------------------------------------------------------------------------
package tplru_pkg;

    localparam int NUM_WAYS    = 8;
    localparam int NUM_SETS    = 64;
    localparam int TAG_WIDTH   = 32;
    localparam int COUNT_WIDTH = 32;

    localparam int WAY_BITS    = $clog2(NUM_WAYS);
    localparam int TREE_DEPTH  = WAY_BITS;
    localparam int NODE_COUNT  = NUM_WAYS - 1;
    localparam int SET_BITS    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    // Fixed field widths of the beats
    localparam int IDX_W      = 6;
    localparam int IN_TAG_W   = 32;
    localparam int OUT_WAY_W  = 3;
    localparam int OUT_CNT_W  = 32;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [IDX_W-1:0]    set_index;
        logic [IN_TAG_W-1:0] tag;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        logic                 evicted_valid;
        logic                 evicted_dirty;
        logic [OUT_CNT_W-1:0] hit_total;
        logic [OUT_CNT_W-1:0] miss_total;
        logic [OUT_CNT_W-1:0] read_miss_total;
        logic [OUT_CNT_W-1:0] write_miss_total;
        logic [OUT_CNT_W-1:0] dirty_evict_total;
    } rsp_t;

    // Per-set state kept beside the tags: line valid, line dirty, tree nodes
    typedef struct packed {
        logic [NUM_WAYS-1:0]   valid;
        logic [NUM_WAYS-1:0]   dirty;
        logic [NODE_COUNT-1:0] tree;
    } meta_t;

    typedef logic [NUM_WAYS-1:0][TAG_WIDTH-1:0] tag_row_t;

    // Fold an incoming set index into range by restoring subtraction.
    function automatic logic [SET_BITS-1:0] set_fold(input logic [IDX_W-1:0] idx);
        int r;
        r = int'(idx);
        for (int k = IDX_W; k >= 0; k--) begin
            if (r >= (NUM_SETS << k)) begin
                r = r - (NUM_SETS << k);
            end
        end
        return SET_BITS'(r);
    endfunction

    // Walk from the root following the node bits to the victim leaf.
    function automatic logic [WAY_BITS-1:0] pick_victim(input logic [NODE_COUNT-1:0] tree);
        int node;
        node = 0;
        for (int k = 0; k < TREE_DEPTH; k++) begin
            node = 2 * node + 1 + int'(tree[node]);
        end
        return WAY_BITS'(node - NODE_COUNT);
    endfunction

    // Point every node on the path to the used way away from it.
    function automatic logic [NODE_COUNT-1:0] touch(input logic [NODE_COUNT-1:0] tree,
                                                    input logic [WAY_BITS-1:0]   way);
        logic [NODE_COUNT-1:0] bits;
        int                    node;
        int                    parent;
        bits = tree;
        node = int'(way) + NODE_COUNT;
        for (int k = 0; k < TREE_DEPTH; k++) begin
            parent = (node - 1) >> 1;
            bits[parent] = node[0];
            node = parent;
        end
        return bits;
    endfunction

endpackage

>>> rtl/core/tree_plru_cache_tag_store.sv
// ----------------------------------------------------------------------------
// tree_plru_cache_tag_store
// Set-associative tag store with tree pseudo-LRU victim selection.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one lookup per beat: read or
//   write, set index and tag. rsp channel (rsp_valid/rsp_ready/rsp) returns
//   one beat per lookup: hit, way used, eviction flags and the five
//   saturating counters after that lookup.
//   Timing: a request is accepted in the idle state, the set row is read from
//   the tag and state memories at that edge, and the lookup state compares,
//   picks the victim and writes the row back while loading the response
//   register, once it can take the beat. Due to the read-then-write-back of
//   the set row, a new request is taken only after the last lookup retires.
//   A response waiting in the output register does not block acceptance of
//   the next request; if the receiver still holds the previous beat when the
//   next lookup finishes, the lookup holds until the register frees.
//   Reset clears the counters, the state machine and one live flag per set
//   row, so every set starts with all lines invalid and the tree at zero.
//   No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tree_plru_cache_tag_store (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  tplru_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output tplru_pkg::rsp_t  rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    localparam int SETS  = tplru_pkg::NUM_SETS;
    localparam int WAYS  = tplru_pkg::NUM_WAYS;
    localparam int SB    = tplru_pkg::SET_BITS;
    localparam int WB    = tplru_pkg::WAY_BITS;
    localparam int TW    = tplru_pkg::TAG_WIDTH;
    localparam int CW    = tplru_pkg::COUNT_WIDTH;

    // Set-row memories: one read port, one write port, registered read data
    tplru_pkg::tag_row_t tag_mem [SETS];
    tplru_pkg::meta_t    meta_mem [SETS];

    state_t              state_reg, state_next;
    logic                is_write_reg;
    logic [SB-1:0]       set_reg;
    logic [TW-1:0]       tag_reg;
    tplru_pkg::tag_row_t tag_rd_reg;
    tplru_pkg::meta_t    meta_rd_reg;
    logic                row_ok_reg;
    logic [SETS-1:0]     row_live_reg;
    logic                rsp_valid_reg;
    tplru_pkg::rsp_t     rsp_reg, rsp_next;

    logic [CW-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CW-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CW-1:0] rmiss_cnt_reg, rmiss_cnt_next;
    logic [CW-1:0] wmiss_cnt_reg, wmiss_cnt_next;
    logic [CW-1:0] devict_cnt_reg, devict_cnt_next;

    logic                req_fire;
    logic [SB-1:0]       set_in;
    logic                finish;
    tplru_pkg::meta_t    meta_cur, meta_new;
    tplru_pkg::tag_row_t tag_row_new;
    logic [WAYS-1:0]     match;
    logic                hit;
    logic [WB-1:0]       hit_way, victim, way_sel;
    logic                ev_valid, ev_dirty;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign set_in    = tplru_pkg::set_fold(req.set_index);
    // Retire the lookup once the output register can take its beat
    assign finish    = (state_reg == ST_LOOKUP) && (!rsp_valid_reg || rsp_ready);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Compare, choose the way and build the written-back row
    always_comb
    begin
        meta_cur = row_ok_reg ? meta_rd_reg : '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = meta_cur.valid[w] && (tag_rd_reg[w] == tag_reg);
        end
        hit     = |match;
        hit_way = '0;
        // Lowest matching way wins: scan from the top down
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WB'(w);
            end
        end
        victim   = tplru_pkg::pick_victim(meta_cur.tree);
        way_sel  = hit ? hit_way : victim;
        ev_valid = !hit && meta_cur.valid[victim];
        ev_dirty = ev_valid && meta_cur.dirty[victim];

        meta_new                = meta_cur;
        meta_new.valid[way_sel] = 1'b1;
        meta_new.dirty[way_sel] = hit ? (meta_cur.dirty[way_sel] || is_write_reg) : 1'b0;
        meta_new.tree           = tplru_pkg::touch(meta_cur.tree, way_sel);

        tag_row_new          = tag_rd_reg;
        tag_row_new[way_sel] = tag_reg;
    end

    // Saturating counters and the response beat
    always_comb
    begin
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        rmiss_cnt_next  = rmiss_cnt_reg;
        wmiss_cnt_next  = wmiss_cnt_reg;
        devict_cnt_next = devict_cnt_reg;
        if (hit) begin
            if (hit_cnt_reg != '1) hit_cnt_next = hit_cnt_reg + 1'b1;
        end else begin
            if (miss_cnt_reg != '1) miss_cnt_next = miss_cnt_reg + 1'b1;
            if (is_write_reg == tplru_pkg::REQ_WRITE) begin
                if (wmiss_cnt_reg != '1) wmiss_cnt_next = wmiss_cnt_reg + 1'b1;
            end else begin
                if (rmiss_cnt_reg != '1) rmiss_cnt_next = rmiss_cnt_reg + 1'b1;
            end
            if (ev_dirty && (devict_cnt_reg != '1)) begin
                devict_cnt_next = devict_cnt_reg + 1'b1;
            end
        end

        rsp_next.hit               = hit;
        rsp_next.way               = tplru_pkg::OUT_WAY_W'(way_sel);
        rsp_next.evicted_valid     = ev_valid;
        rsp_next.evicted_dirty     = ev_dirty;
        rsp_next.hit_total         = tplru_pkg::OUT_CNT_W'(hit_cnt_next);
        rsp_next.miss_total        = tplru_pkg::OUT_CNT_W'(miss_cnt_next);
        rsp_next.read_miss_total   = tplru_pkg::OUT_CNT_W'(rmiss_cnt_next);
        rsp_next.write_miss_total  = tplru_pkg::OUT_CNT_W'(wmiss_cnt_next);
        rsp_next.dirty_evict_total = tplru_pkg::OUT_CNT_W'(devict_cnt_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (req_fire) state_next = ST_LOOKUP;
            ST_LOOKUP: if (finish)   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memories: read the set row on accept, write it back on retire
    always_ff @(posedge clk)
    begin
        if (req_fire) begin
            tag_rd_reg  <= tag_mem[set_in];
            meta_rd_reg <= meta_mem[set_in];
        end
        if (finish) begin
            meta_mem[set_reg] <= meta_new;
            if (!hit) begin
                tag_mem[set_reg] <= tag_row_new;
            end
        end
    end

    // Request payload capture
    always_ff @(posedge clk)
    begin
        if (req_fire) begin
            is_write_reg <= req.req_type;
            set_reg      <= set_in;
            tag_reg      <= TW'(req.tag);
        end
        if (finish) begin
            rsp_reg <= rsp_next;
        end
    end

    // State, live rows, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            row_ok_reg     <= 1'b0;
            row_live_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            rmiss_cnt_reg  <= '0;
            wmiss_cnt_reg  <= '0;
            devict_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (req_fire) begin
                row_ok_reg <= row_live_reg[set_in];
            end
            if (finish) begin
                row_live_reg[set_reg] <= 1'b1;
                rsp_valid_reg         <= 1'b1;
                hit_cnt_reg           <= hit_cnt_next;
                miss_cnt_reg          <= miss_cnt_next;
                rmiss_cnt_reg         <= rmiss_cnt_next;
                wmiss_cnt_reg         <= wmiss_cnt_next;
                devict_cnt_reg        <= devict_cnt_next;
            end else if (rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Every accepted request moves straight into the lookup state
    `TPLRU_ASSERT(a_accept_to_lookup, clk, rst_n, req_fire |=> (state_reg == ST_LOOKUP), "accepted request did not enter lookup")
    // A new response beat only ever comes out of a lookup
    `TPLRU_ASSERT_IMP(a_rsp_from_lookup, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg == ST_LOOKUP), "response appeared without a lookup")
    // Hit counter moves only when a lookup retires
    `TPLRU_ASSERT_IMP(a_cnt_on_retire, clk, rst_n, hit_cnt_reg != $past(hit_cnt_reg), $past(finish), "hit counter changed outside a retire")
    // A hit never reports an eviction
    `TPLRU_ASSERT_IMP(a_hit_no_evict, clk, rst_n, rsp_valid_reg && rsp_reg.hit, !rsp_reg.evicted_valid && !rsp_reg.evicted_dirty, "hit reported an eviction")

endmodule

>>> tb/tree_plru_cache_tag_store_tb.sv
// ----------------------------------------------------------------------------
// tree_plru_cache_tag_store_tb
// Self-checking bench for the pseudo-LRU tag store: a queue-fed driver offers
// lookups, a predictor tracks tags, line flags, tree bits and counters, and a
// monitor compares every response beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tree_plru_cache_tag_store_tb;

    // One queued lookup, or a marker that holds the sender until the block
    // has answered everything in flight.
    typedef struct {
        tplru_pkg::req_t beat;
        bit              hold_for_drain;
    } lookup_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    tplru_pkg::req_t req = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    tplru_pkg::rsp_t rsp;

    // Shadow copy of the tag store
    logic [tplru_pkg::TAG_WIDTH-1:0] shadow_tag   [tplru_pkg::NUM_SETS][tplru_pkg::NUM_WAYS];
    bit                              shadow_live  [tplru_pkg::NUM_SETS][tplru_pkg::NUM_WAYS];
    bit                              shadow_dirty [tplru_pkg::NUM_SETS][tplru_pkg::NUM_WAYS];
    logic [tplru_pkg::NUM_WAYS-2:0]  shadow_tree  [tplru_pkg::NUM_SETS];
    logic [tplru_pkg::OUT_CNT_W-1:0] hits;
    logic [tplru_pkg::OUT_CNT_W-1:0] misses;
    logic [tplru_pkg::OUT_CNT_W-1:0] rd_miss_tally;
    logic [tplru_pkg::OUT_CNT_W-1:0] wr_miss_tally;
    logic [tplru_pkg::OUT_CNT_W-1:0] dirty_evictions;

    lookup_t         lookup_q[$];
    tplru_pkg::rsp_t expected_rsp_q[$];

    int              total_count = 0;
    int              sent_count = 0;
    int              checked_count = 0;
    int              mismatch_count = 0;
    int              stall_left = 0;
    bit              held_off = 1'b0;
    tplru_pkg::rsp_t want;

    tree_plru_cache_tag_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [tplru_pkg::OUT_CNT_W-1:0] sat_inc(
        input logic [tplru_pkg::OUT_CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Advance the shadow store by one lookup and return the response it implies.
    function automatic tplru_pkg::rsp_t predict_lookup(input tplru_pkg::req_t beat);
        tplru_pkg::rsp_t                out;
        int                             set;
        int                             node;
        int                             parent;
        bit                             found;
        logic [tplru_pkg::WAY_BITS-1:0] way;
        out = '0;
        set = int'(beat.set_index) % tplru_pkg::NUM_SETS;
        found = 1'b0;
        way = '0;
        // Lowest valid way with a matching tag wins
        for (int w = 0; w < tplru_pkg::NUM_WAYS; w++)
        begin
            if (!found && shadow_live[set][w] && shadow_tag[set][w] == beat.tag)
            begin
                found = 1'b1;
                way = tplru_pkg::WAY_BITS'(w);
            end
        end
        if (found)
        begin
            hits = sat_inc(hits);
            if (beat.req_type == tplru_pkg::REQ_WRITE)
                shadow_dirty[set][way] = 1'b1;
        end
        else
        begin
            misses = sat_inc(misses);
            if (beat.req_type == tplru_pkg::REQ_WRITE)
                wr_miss_tally = sat_inc(wr_miss_tally);
            else
                rd_miss_tally = sat_inc(rd_miss_tally);
            // Follow the node bits down from the root; the tree alone decides
            node = 0;
            for (int lvl = 0; lvl < tplru_pkg::WAY_BITS; lvl++)
                node = 2 * node + 1 + int'(shadow_tree[set][node]);
            way = tplru_pkg::WAY_BITS'(node - (tplru_pkg::NUM_WAYS - 1));
            out.evicted_valid = shadow_live[set][way];
            out.evicted_dirty = shadow_live[set][way] && shadow_dirty[set][way];
            if (out.evicted_dirty)
                dirty_evictions = sat_inc(dirty_evictions);
            shadow_tag[set][way]   = beat.tag;
            shadow_live[set][way]  = 1'b1;
            shadow_dirty[set][way] = 1'b0;
        end
        // Point each node on the leaf path toward the sibling of the used branch
        node = int'(way) + tplru_pkg::NUM_WAYS - 1;
        while (node > 0)
        begin
            parent = (node - 1) / 2;
            shadow_tree[set][parent] = (node % 2 == 1);
            node = parent;
        end
        out.hit               = found;
        out.way               = way;
        out.hit_total         = hits;
        out.miss_total        = misses;
        out.read_miss_total   = rd_miss_tally;
        out.write_miss_total  = wr_miss_tally;
        out.dirty_evict_total = dirty_evictions;
        return out;
    endfunction

    function automatic bit same_rsp(input tplru_pkg::rsp_t a, input tplru_pkg::rsp_t b);
        return (a.hit === b.hit) && (a.way === b.way)
            && (a.evicted_valid === b.evicted_valid)
            && (a.evicted_dirty === b.evicted_dirty)
            && (a.hit_total === b.hit_total)
            && (a.miss_total === b.miss_total)
            && (a.read_miss_total === b.read_miss_total)
            && (a.write_miss_total === b.write_miss_total)
            && (a.dirty_evict_total === b.dirty_evict_total);
    endfunction

    task automatic add_lookup(input logic kind, input int set, input logic [31:0] tag);
        lookup_t item;
        item.beat.req_type  = kind;
        item.beat.set_index = tplru_pkg::IDX_W'(set);
        item.beat.tag       = tag;
        item.hold_for_drain = 1'b0;
        lookup_q.push_back(item);
        total_count++;
    endtask

    task automatic add_drain();
        lookup_t item;
        item.beat = '0;
        item.hold_for_drain = 1'b1;
        lookup_q.push_back(item);
    endtask

    // ------------------------------------------------------------------------
    // Request driver. Predict each beat at the edge that accepts it, then
    // either hold the beat, present the next one, or idle. Idling is switched
    // off for a stretch in the middle of the run so back-to-back traffic is
    // also exercised. A drain marker keeps valid low until all responses are
    // back.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp_q.push_back(predict_lookup(req));
                sent_count++;
            end
            if (!req_valid || req_ready)
            begin
                if (lookup_q.size() != 0 && lookup_q[0].hold_for_drain)
                begin
                    // Release the pause only once nothing is outstanding
                    if (expected_rsp_q.size() == 0)
                        void'(lookup_q.pop_front());
                    req_valid <= 1'b0;
                end
                else if (lookup_q.size() == 0
                         || (!(sent_count >= 450 && sent_count < 650)
                             && $urandom_range(99) < 9))
                begin
                    req_valid <= 1'b0;
                end
                else
                begin
                    req       <= lookup_q[0].beat;
                    req_valid <= 1'b1;
                    void'(lookup_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Check each accepted beat against the oldest
    // prediction, then pick next cycle's ready. Once, after 300 responses,
    // hold ready low for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("response %0d arrived with nothing outstanding",
                                 checked_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (!same_rsp(want, rsp))
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("response %0d: expected hit=%0b way=%0d ev=%0b/%0b",
                                     checked_count, want.hit, want.way,
                                     want.evicted_valid, want.evicted_dirty);
                            $display("  counts %0d/%0d/%0d/%0d/%0d",
                                     want.hit_total, want.miss_total,
                                     want.read_miss_total, want.write_miss_total,
                                     want.dirty_evict_total);
                            $display("  actual hit=%0b way=%0d ev=%0b/%0b",
                                     rsp.hit, rsp.way, rsp.evicted_valid,
                                     rsp.evicted_dirty);
                            $display("  counts %0d/%0d/%0d/%0d/%0d",
                                     rsp.hit_total, rsp.miss_total,
                                     rsp.read_miss_total, rsp.write_miss_total,
                                     rsp.dirty_evict_total);
                        end
                        mismatch_count++;
                    end
                end
                checked_count++;
            end
            if (!held_off && checked_count >= 300)
            begin
                held_off   = 1'b1;
                stall_left = 80;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (checked_count >= 450 && checked_count < 650)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 9);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] tag_pool [16];
        int          hot_sets [4];
        int          set;
        logic [31:0] tag;

        for (int s = 0; s < tplru_pkg::NUM_SETS; s++)
        begin
            shadow_tree[s] = '0;
            for (int w = 0; w < tplru_pkg::NUM_WAYS; w++)
            begin
                shadow_tag[s][w]   = '0;
                shadow_live[s][w]  = 1'b0;
                shadow_dirty[s][w] = 1'b0;
            end
        end
        hits = '0;
        misses = '0;
        rd_miss_tally = '0;
        wr_miss_tally = '0;
        dirty_evictions = '0;

        // Set 0: cold read miss, write hit dirties way 0, read hit, then eight
        // new tags; the eighth sweeps the tree back onto the dirty line.
        add_lookup(tplru_pkg::REQ_READ, 0, 32'h0000_0000);
        add_lookup(tplru_pkg::REQ_WRITE, 0, 32'h0000_0000);
        add_lookup(tplru_pkg::REQ_READ, 0, 32'h0000_0000);
        for (int k = 1; k <= 8; k++)
            add_lookup((k % 2 == 1) ? tplru_pkg::REQ_WRITE : tplru_pkg::REQ_READ, 0, 32'(k));
        // Top set and all-ones tag
        add_lookup(tplru_pkg::REQ_WRITE, 63, 32'hFFFF_FFFF);
        add_lookup(tplru_pkg::REQ_READ, 63, 32'hFFFF_FFFF);
        // Set 42: five fills, two hits that steer the tree back onto a valid
        // way while three ways are still empty, then a miss that evicts it.
        for (int k = 0; k < 5; k++)
            add_lookup((k == 0) ? tplru_pkg::REQ_WRITE : tplru_pkg::REQ_READ, 42,
                       32'h8000_0000 | 32'(k));
        add_lookup(tplru_pkg::REQ_READ, 42, 32'h8000_0002);
        add_lookup(tplru_pkg::REQ_WRITE, 42, 32'h8000_0003);
        add_lookup(tplru_pkg::REQ_READ, 42, 32'h8000_0005);
        add_drain();

        // Random part: mostly a small tag pool on a few hot sets, so hits,
        // refills and dirty evictions keep coming; the rest is wide noise.
        tag_pool[0] = 32'h0000_0000;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 16; k++)
            tag_pool[k] = $urandom;
        hot_sets[0] = 5;
        hot_sets[1] = 17;
        hot_sets[2] = 40;
        hot_sets[3] = 63;
        for (int n = 0; n < 830; n++)
        begin
            if ($urandom_range(99) < 60)
                set = hot_sets[$urandom_range(3)];
            else
                set = $urandom_range(tplru_pkg::NUM_SETS - 1);
            if ($urandom_range(99) < 80)
                tag = tag_pool[$urandom_range(11)];
            else
                tag = $urandom;
            add_lookup($urandom_range(1) ? tplru_pkg::REQ_WRITE : tplru_pkg::REQ_READ,
                       set, tag);
            if (n == 700)
                add_drain();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every queued lookup has come back, then allow a short
        // tail for any stray beat.
        while (checked_count < total_count)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
